// File: hw/rtl/wlcv_pkg.sv
// ----------------------------------------------------------------------------
// wlcv_pkg
// Shared types, constants and controller state codes of the windowed linear
// classifier with majority vote.
// ----------------------------------------------------------------------------
package wlcv_pkg;

  localparam int Channels     = 4;
  localparam int MaxClasses   = 8;
  localparam int FeatureDepth = 64;
  localparam int VoteDepth    = 64;
  localparam int SampleBits   = 16;
  localparam int CoefBits     = 16;
  localparam int ScoreBits    = 40;
  localparam int AccBits      = 36;

  // request kinds
  localparam logic [1:0] REQ_COEF   = 2'd0;
  localparam logic [1:0] REQ_SAMPLE = 2'd1;
  localparam logic [1:0] REQ_CLEAR  = 2'd2;

  // configuration register indexes
  localparam logic [2:0] CFG_NUM_CLASSES    = 3'd0;
  localparam logic [2:0] CFG_CHANNEL_COUNT  = 3'd1;
  localparam logic [2:0] CFG_FEATURE_WINDOW = 3'd2;
  localparam logic [2:0] CFG_VOTE_WINDOW    = 3'd3;
  localparam logic [2:0] CFG_VOTE_SPACING   = 3'd4;
  localparam logic [2:0] CFG_MODEL_ENABLE   = 3'd5;

  // controller states, also the command to the datapath
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SRD    = 4'd1;
  localparam logic [3:0] S_ICP_RD = 4'd2;
  localparam logic [3:0] S_ICP_LD = 4'd3;
  localparam logic [3:0] S_W_RD   = 4'd4;
  localparam logic [3:0] S_W_MUL  = 4'd5;
  localparam logic [3:0] S_W_ADD  = 4'd6;
  localparam logic [3:0] S_CLS    = 4'd7;
  localparam logic [3:0] S_PUSH   = 4'd8;
  localparam logic [3:0] S_MOD    = 4'd9;
  localparam logic [3:0] S_V_RD   = 4'd10;
  localparam logic [3:0] S_V_CNT  = 4'd11;
  localparam logic [3:0] S_TALLY  = 4'd12;
  localparam logic [3:0] S_OUT    = 4'd13;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [2:0]         coef_class;
    logic [2:0]         coef_index;
    logic signed [31:0] coef_value;
    logic signed [15:0] sample_0;
    logic signed [15:0] sample_1;
    logic signed [15:0] sample_2;
    logic signed [15:0] sample_3;
  } req_t;

  typedef struct packed {
    logic [2:0]         frame_label;
    logic signed [39:0] best_score;
    logic               vote_taken;
    logic [2:0]         predicted_class;
    logic               predicted_valid;
  } res_t;

  typedef struct packed {
    logic [3:0] op;
    logic       take;
  } cmd_t;

  typedef struct packed {
    logic frame;
    logic ch_last;
    logic cls_last;
    logic mod_ge;
    logic vote_go;
    logic k_done;
    logic t_done;
    logic out_free;
  } stat_t;

endpackage

// File: hw/rtl/wlcv_if.sv
// ----------------------------------------------------------------------------
// wlcv_req_if / wlcv_res_if
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
interface wlcv_req_if;
  logic          valid;
  logic          ready;
  wlcv_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface wlcv_res_if;
  logic          valid;
  logic          ready;
  wlcv_pkg::res_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: hw/rtl/wlcv_ctrl.sv
// ----------------------------------------------------------------------------
// wlcv_ctrl
// Sequencer: walks one sample item through scoring, label push, spacing
// check, vote walk and tally, then hands the result to the output register.
// ----------------------------------------------------------------------------
module wlcv_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  wlcv_pkg::stat_t st,
  output wlcv_pkg::cmd_t  cmd
);
  import wlcv_pkg::*;

  logic [3:0] state, state_next;

  assign in_ready = (state == S_IDLE) && !rst;
  assign cmd.op   = state;
  assign cmd.take = in_valid && in_ready;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (cmd.take && st.frame) state_next = S_SRD;
      S_SRD:    state_next = S_ICP_RD;
      S_ICP_RD: state_next = S_ICP_LD;
      S_ICP_LD: state_next = S_W_RD;
      S_W_RD:   state_next = S_W_MUL;
      S_W_MUL:  state_next = S_W_ADD;
      S_W_ADD:  state_next = st.ch_last ? S_CLS : S_W_RD;
      S_CLS:    state_next = st.cls_last ? S_PUSH : S_ICP_RD;
      S_PUSH:   state_next = S_MOD;
      S_MOD: begin
        if (st.mod_ge)       state_next = S_MOD;
        else if (st.vote_go) state_next = S_V_RD;
        else                 state_next = S_OUT;
      end
      S_V_RD:   state_next = st.k_done ? S_TALLY : S_V_CNT;
      S_V_CNT:  state_next = S_V_RD;
      S_TALLY:  if (st.t_done) state_next = S_OUT;
      S_OUT:    if (st.out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

endmodule

// File: hw/rtl/wlcv_dp.sv
// ----------------------------------------------------------------------------
// wlcv_dp
// Datapath: configuration registers, sample/coefficient/label memories,
// multiply-accumulate, argmax, spacing remainder, vote counts and the
// output register.
// ----------------------------------------------------------------------------
module wlcv_dp (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic [2:0]      cfg_index,
  input  logic [6:0]      cfg_wdata,
  input  wlcv_pkg::req_t  req,
  input  wlcv_pkg::cmd_t  cmd,
  output wlcv_pkg::stat_t st,
  output logic            res_valid,
  input  logic            res_ready,
  output wlcv_pkg::res_t  res
);
  import wlcv_pkg::*;

  // configuration
  logic [3:0] num_classes;
  logic [2:0] channel_count;
  logic [6:0] feature_window, vote_window, vote_spacing;
  logic       model_enable;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_classes    <= 4'd2;
      channel_count  <= 3'd4;
      feature_window <= 7'd1;
      vote_window    <= 7'd1;
      vote_spacing   <= 7'd1;
      model_enable   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_NUM_CLASSES:    num_classes    <= cfg_wdata[3:0];
        CFG_CHANNEL_COUNT:  channel_count  <= cfg_wdata[2:0];
        CFG_FEATURE_WINDOW: feature_window <= cfg_wdata;
        CFG_VOTE_WINDOW:    vote_window    <= cfg_wdata;
        CFG_VOTE_SPACING:   vote_spacing   <= cfg_wdata;
        CFG_MODEL_ENABLE:   model_enable   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // clamped settings
  logic [3:0] cc;
  logic [2:0] nch;
  logic [6:0] fw, vw, vs;
  assign cc  = (num_classes < 4'd2) ? 4'd2 : (num_classes > 4'd8) ? 4'd8 : num_classes;
  assign nch = (channel_count == 3'd0) ? 3'd1 :
               (channel_count > 3'd4) ? 3'd4 : channel_count;
  assign fw  = (feature_window == 7'd0) ? 7'd1 :
               (feature_window > 7'd64) ? 7'd64 : feature_window;
  assign vw  = (vote_window == 7'd0) ? 7'd1 :
               (vote_window > 7'd64) ? 7'd64 : vote_window;
  assign vs  = (vote_spacing == 7'd0) ? 7'd1 : vote_spacing;

  // loop and control registers
  logic [5:0] wp, vp;
  logic [6:0] sheld, vheld;
  logic [5:0] cnt, rem;
  logic       vfull;
  logic [2:0] ci;
  logic [1:0] cch;
  logic [6:0] k;
  logic [3:0] ti;
  logic [2:0] win, label, voted_class;
  logic [6:0] best_cnt;
  logic       voted_valid, taken;
  logic [6:0] counts [MaxClasses];

  logic [7:0] sheld_inc, vheld_inc;
  logic [6:0] sheld_new, vheld_new, cnt_inc;
  logic [5:0] cnt_new;
  assign sheld_inc = {1'b0, sheld} + 8'd1;
  assign sheld_new = (sheld_inc >= {1'b0, fw}) ? fw : sheld_inc[6:0];
  assign vheld_inc = {1'b0, vheld} + 8'd1;
  assign vheld_new = (vheld_inc >= {1'b0, vw}) ? vw : vheld_inc[6:0];
  assign cnt_inc   = {1'b0, cnt} + 7'd1;
  assign cnt_new   = (cnt_inc >= vw || cnt_inc > 7'd63) ? 6'd0 : cnt_inc[5:0];

  // memories
  logic [63:0]               smem [FeatureDepth];
  logic [CoefBits-1:0]       wmem [MaxClasses*Channels];
  logic [31:0]               imem [MaxClasses];
  logic [2:0]                vmem [VoteDepth];
  logic [63:0]               srd;
  logic signed [CoefBits-1:0] wrd;
  logic signed [31:0]        ird;
  logic [2:0]                vrd;

  logic [5:0]  sra, vra;
  logic [15:0] wsat;
  assign sra = wp - fw[5:0];
  assign vra = vp - vw[5:0] + k[5:0];
  assign wsat = (req.coef_value > 32'sd32767)  ? 16'h7fff :
                (req.coef_value < -32'sd32768) ? 16'h8000 : req.coef_value[15:0];

  logic take_sample;
  assign take_sample = cmd.take && req.req_type == REQ_SAMPLE && model_enable;

  always_ff @(posedge clk) begin
    if (take_sample) smem[wp] <= {req.sample_3, req.sample_2, req.sample_1, req.sample_0};
    if (cmd.op == S_SRD) srd <= smem[sra];
  end

  always_ff @(posedge clk) begin
    if (cmd.take && req.req_type == REQ_COEF && req.coef_index < 3'd4)
      wmem[{req.coef_class, req.coef_index[1:0]}] <= wsat;
    if (cmd.op == S_W_RD) wrd <= wmem[{ci, cch}];
  end

  always_ff @(posedge clk) begin
    if (cmd.take && req.req_type == REQ_COEF && req.coef_index == 3'd4)
      imem[req.coef_class] <= req.coef_value;
    if (cmd.op == S_ICP_RD) ird <= imem[ci];
  end

  always_ff @(posedge clk) begin
    if (cmd.op == S_PUSH) vmem[vp] <= label;
    if (cmd.op == S_V_RD) vrd <= vmem[vra];
  end

  // multiply-accumulate
  logic signed [SampleBits-1:0] feat;
  logic signed [31:0]           prod;
  logic signed [AccBits-1:0]    acc, best;
  assign feat = srd[{cch, 4'd0} +: 16];

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      S_ICP_LD: acc <= {{2{ird[31]}}, ird, 2'b00};
      S_W_MUL:  prod <= wrd * feat;
      S_W_ADD:  acc <= acc + {{(AccBits-32){prod[31]}}, prod};
      S_CLS: if (ci == 3'd0 || acc > best) begin
        best  <= acc;
        label <= ci;
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0; vp <= '0; sheld <= '0; vheld <= '0; cnt <= '0;
      voted_class <= '0; voted_valid <= 1'b0; res_valid <= 1'b0;
    end else begin
      if (cmd.take && req.req_type == REQ_CLEAR) begin
        sheld <= '0;
        vheld <= '0;
      end
      if (take_sample) begin
        wp    <= wp + 6'd1;
        sheld <= sheld_new;
      end
      if (cmd.op == S_PUSH) begin
        vp    <= vp + 6'd1;
        vheld <= vheld_new;
        cnt   <= cnt_new;
      end
      if (cmd.op == S_TALLY && st.t_done) begin
        voted_class <= win;
        voted_valid <= 1'b1;
      end
      if (cmd.op == S_OUT && st.out_free) res_valid <= 1'b1;
      else if (res_ready)                 res_valid <= 1'b0;
    end
  end

  // loop counters, remainder and vote tally
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      S_SRD:    ci <= '0;
      S_ICP_LD: cch <= '0;
      S_W_ADD:  cch <= cch + 2'd1;
      S_CLS:    ci <= ci + 3'd1;
      S_PUSH: begin
        rem   <= cnt_new;
        vfull <= (vheld_new >= vw);
        k     <= '0;
        taken <= 1'b0;
        for (int j = 0; j < MaxClasses; j++) counts[j] <= '0;
      end
      S_MOD: if (st.mod_ge) rem <= rem - vs[5:0];
      S_V_RD: if (st.k_done) begin
        best_cnt <= counts[0];
        win      <= '0;
        ti       <= 4'd1;
      end
      S_V_CNT: begin
        for (int j = 0; j < MaxClasses; j++)
          if (vrd == 3'(j) && {1'b0, vrd} < cc) counts[j] <= counts[j] + 7'd1;
        k <= k + fw;
      end
      S_TALLY: begin
        if (!st.t_done) begin
          if (counts[ti[2:0]] > best_cnt) begin
            best_cnt <= counts[ti[2:0]];
            win      <= ti[2:0];
          end
          ti <= ti + 4'd1;
        end else begin
          taken <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.op == S_OUT && st.out_free) begin
      res.frame_label     <= label;
      res.best_score      <= {{(ScoreBits-AccBits){best[AccBits-1]}}, best};
      res.vote_taken      <= taken;
      res.predicted_class <= voted_class;
      res.predicted_valid <= voted_valid;
    end
  end

  // status
  assign st.frame    = req.req_type == REQ_SAMPLE && model_enable && sheld_inc >= {1'b0, fw};
  assign st.ch_last  = {1'b0, cch} == nch - 3'd1;
  assign st.cls_last = {1'b0, ci} == cc - 4'd1;
  assign st.mod_ge   = {1'b0, rem} >= vs;
  assign st.vote_go  = rem == 6'd0 && vfull;
  assign st.k_done   = k >= vw;
  assign st.t_done   = ti >= cc;
  assign st.out_free = !res_valid || res_ready;

endmodule

// File: hw/rtl/windowed_linear_classifier_vote_core.sv
// ----------------------------------------------------------------------------
// windowed_linear_classifier_vote_core
// Streaming linear classifier over a sample window with majority voting of
// the frame labels.
// ----------------------------------------------------------------------------
//  channel | dir | handshake         | payload
//  req     | in  | req.valid/ready   | req_type, coef_*, sample_0..3
//  res     | out | res.valid/ready   | frame_label, best_score, vote fields
//  cfg     | in  | cfg_we            | cfg_index, cfg_wdata
//
//  Coefficient loads, clears and non-frame samples are handled in the idle
//  state; a frame runs the per-class scoring loop on the one shared multiplier,
//  the spacing check and, when a vote is taken, the vote walk and tally.
//  Synchronous reset clears counts, pointers and the prediction; memories
//  are not cleared. A stalled result holds in the output register while the
//  next item is accepted; the sequencer waits only to reload it.
// ----------------------------------------------------------------------------
module windowed_linear_classifier_vote_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [6:0] cfg_wdata,
  wlcv_req_if.sink   req,
  wlcv_res_if.source res
);
  import wlcv_pkg::*;

  cmd_t  cmd;
  stat_t st;

  wlcv_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .st       (st),
    .cmd      (cmd)
  );

  wlcv_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .req       (req.data),
    .cmd       (cmd),
    .st        (st),
    .res_valid (res.valid),
    .res_ready (res.ready),
    .res       (res.data)
  );

endmodule

// File: hw/rtl/wlcv_checker.sv
// ----------------------------------------------------------------------------
// wlcv_checker
// Port-level checks of the classifier core, bound to the top level.
// ----------------------------------------------------------------------------
module wlcv_checker (
  input logic           clk,
  input logic           rst,
  input logic           res_valid,
  input logic           res_ready,
  input wlcv_pkg::res_t res_data
);
  logic seen_valid;

  // a valid prediction never goes back to invalid
  always_ff @(posedge clk) begin
    if (rst) seen_valid <= 1'b0;
    else if (res_valid && res_data.predicted_valid) seen_valid <= 1'b1;
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result dropped while stalled");

  a_reset: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  a_taken: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.vote_taken |-> res_data.predicted_valid)
    else $error("vote taken without valid prediction");

  a_sticky: assert property (@(posedge clk) disable iff (rst)
    res_valid && seen_valid |-> res_data.predicted_valid)
    else $error("prediction lost its valid flag");

endmodule

bind windowed_linear_classifier_vote_core wlcv_checker u_wlcv_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (res.valid),
  .res_ready (res.ready),
  .res_data  (res.data)
);

// File: dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for windowed_linear_classifier_vote_core. A behavioral
// predictor tracks coefficients, both windows, the spacing counter and the
// vote. It checks every result against its expected value, under random
// gaps on both channels and a range of register settings.
// ----------------------------------------------------------------------------
module tb;
  import wlcv_pkg::*;

  localparam int  SettleCycles = 500;
  localparam longint CycleLimit = 3000000;

  logic       clk;
  logic       rst;
  logic       cfg_we;
  logic [2:0] cfg_index;
  logic [6:0] cfg_wdata;

  wlcv_req_if req_if ();
  wlcv_res_if res_if ();

  windowed_linear_classifier_vote_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .req       (req_if.sink),
    .res       (res_if.source)
  );

  // predictor copy of the registers
  int unsigned reg_classes, reg_channels, reg_fwin, reg_vwin, reg_spacing, reg_enable;

  // predictor copy of the block state
  logic signed [15:0] sample_hist [FeatureDepth][Channels];
  int unsigned        samples_in;
  logic signed [15:0] weights [MaxClasses][Channels];
  logic signed [31:0] intercepts [MaxClasses];
  logic [2:0]         label_hist [VoteDepth];
  int unsigned        labels_in;
  int unsigned        pace_count;
  logic [2:0]         vote_class;
  logic               vote_valid;

  res_t   expected_results [$];
  int     errors;
  int     frames_seen;
  int     votes_seen;
  int     items_sent;
  longint cycles;
  bit     quiet_mode;
  int     hold_left;
  int     stall_left;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CycleLimit) begin
        $display("%0t: timeout, %0d results still expected", $time, expected_results.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  function automatic int unsigned clamp(int unsigned v, int unsigned lo, int unsigned hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // advance the predictor by one accepted item; queue a result if it makes one
  function automatic void classify_item(req_t r);
    int unsigned cc, nch, fw, vw, vs, nxt, win;
    longint      acc, best, v;
    logic [2:0]  lbl;
    int unsigned tally [MaxClasses];
    bit          taken;
    res_t        e;
    cc  = clamp(reg_classes, 2, MaxClasses);
    nch = clamp(reg_channels, 1, Channels);
    fw  = clamp(reg_fwin, 1, FeatureDepth);
    vw  = clamp(reg_vwin, 1, VoteDepth);
    vs  = reg_spacing == 0 ? 1 : reg_spacing;
    best = 0;
    lbl = '0;
    taken = 1'b0;
    case (r.req_type)
      REQ_COEF: begin
        v = longint'(r.coef_value);
        if (r.coef_index < Channels)
          weights[r.coef_class][r.coef_index] =
            v > 32767 ? 16'sh7fff : (v < -32768 ? -16'sh8000 : v[15:0]);
        else if (r.coef_index == Channels)
          intercepts[r.coef_class] = r.coef_value;
        return;
      end
      REQ_CLEAR: begin
        samples_in = 0;
        labels_in = 0;
        return;
      end
      REQ_SAMPLE: if (reg_enable == 0) return;
      default: return;
    endcase
    for (int k = FeatureDepth - 1; k > 0; k--) sample_hist[k] = sample_hist[k - 1];
    sample_hist[0][0] = r.sample_0;
    sample_hist[0][1] = r.sample_1;
    sample_hist[0][2] = r.sample_2;
    sample_hist[0][3] = r.sample_3;
    samples_in = (samples_in + 1 >= fw) ? fw : samples_in + 1;
    if (samples_in < fw) return;
    // scores and argmax, ties to the lowest class
    for (int i = 0; i < cc; i++) begin
      acc = longint'(intercepts[i]) * 4;
      for (int c = 0; c < nch; c++)
        acc += longint'(weights[i][c]) * longint'(sample_hist[fw - 1][c]);
      if (acc > 64'sh7f_ffff_ffff) acc = 64'sh7f_ffff_ffff;
      if (acc < -64'sh80_0000_0000) acc = -64'sh80_0000_0000;
      if (i == 0 || acc > best) begin
        best = acc;
        lbl = i[2:0];
      end
    end
    for (int k = VoteDepth - 1; k > 0; k--) label_hist[k] = label_hist[k - 1];
    label_hist[0] = lbl;
    labels_in = (labels_in + 1 >= vw) ? vw : labels_in + 1;
    nxt = pace_count + 1;
    pace_count = (nxt >= vw || nxt > 63) ? 0 : nxt;
    // majority vote over every fw-th label, oldest first
    if (labels_in >= vw && pace_count % vs == 0) begin
      foreach (tally[i]) tally[i] = 0;
      for (int unsigned k = 0; k < vw; k += fw)
        if (label_hist[vw - 1 - k] < cc) tally[label_hist[vw - 1 - k]]++;
      win = 0;
      for (int i = 1; i < cc; i++) if (tally[i] > tally[win]) win = i;
      vote_class = win[2:0];
      vote_valid = 1'b1;
      taken = 1'b1;
    end
    e.frame_label     = lbl;
    e.best_score      = best[39:0];
    e.vote_taken      = taken;
    e.predicted_class = vote_class;
    e.predicted_valid = vote_valid;
    expected_results.insert(expected_results.size(), e);
  endfunction

  // result checker
  initial begin
    errors = 0;
    frames_seen = 0;
    votes_seen = 0;
    forever begin
      @(posedge clk);
      if (!rst && res_if.valid && res_if.ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result with none expected: %p", $time, res_if.data);
          errors++;
        end else begin
          res_t e;
          e = expected_results.pop_front();
          frames_seen++;
          if (res_if.data.vote_taken) votes_seen++;
          if (res_if.data.frame_label !== e.frame_label) begin
            $display("%0t: frame_label exp %0d got %0d", $time, e.frame_label,
                     res_if.data.frame_label);
            errors++;
          end
          if (res_if.data.best_score !== e.best_score) begin
            $display("%0t: best_score exp %0d got %0d", $time, e.best_score,
                     res_if.data.best_score);
            errors++;
          end
          if (res_if.data.vote_taken !== e.vote_taken) begin
            $display("%0t: vote_taken exp %0d got %0d", $time, e.vote_taken,
                     res_if.data.vote_taken);
            errors++;
          end
          if (res_if.data.predicted_class !== e.predicted_class) begin
            $display("%0t: predicted_class exp %0d got %0d", $time, e.predicted_class,
                     res_if.data.predicted_class);
            errors++;
          end
          if (res_if.data.predicted_valid !== e.predicted_valid) begin
            $display("%0t: predicted_valid exp %0d got %0d", $time, e.predicted_valid,
                     res_if.data.predicted_valid);
            errors++;
          end
        end
      end
    end
  end

  // result receiver: random stalls per item, plus long hold-offs on request
  initial begin
    res_if.ready = 1'b0;
    hold_left = 0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        res_if.ready = 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        res_if.ready = 1'b0;
        stall_left--;
      end else begin
        res_if.ready = 1'b1;
      end
      @(posedge clk);
      if (res_if.valid && res_if.ready) stall_left = quiet_mode ? 0 : $urandom_range(0, 11);
    end
  end

  // send one item after a random gap; valid stays high until the next gap
  task automatic send_item(req_t r);
    int gap;
    gap = quiet_mode ? 0 : $urandom_range(0, 11);
    @(negedge clk);
    if (gap > 0) begin
      req_if.valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    req_if.data = r;
    req_if.valid = 1'b1;
    do @(posedge clk); while (!req_if.ready);
    classify_item(r);
    items_sent++;
  endtask

  // drop valid, then wait until every result is in and the block is quiet
  task automatic drain();
    @(negedge clk);
    req_if.valid = 1'b0;
    wait (expected_results.size() == 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, int unsigned val);
    @(negedge clk);
    req_if.valid = 1'b0;
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val[6:0];
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      CFG_NUM_CLASSES:    reg_classes  = val & 4'hf;
      CFG_CHANNEL_COUNT:  reg_channels = val & 3'h7;
      CFG_FEATURE_WINDOW: reg_fwin     = val & 7'h7f;
      CFG_VOTE_WINDOW:    reg_vwin     = val & 7'h7f;
      CFG_VOTE_SPACING:   reg_spacing  = val & 7'h7f;
      CFG_MODEL_ENABLE:   reg_enable   = val & 1;
      default: ;
    endcase
  endtask

  task automatic set_config(int unsigned cc, int unsigned nch, int unsigned fw,
                            int unsigned vw, int unsigned vs, int unsigned en);
    write_reg(CFG_NUM_CLASSES, cc);
    write_reg(CFG_CHANNEL_COUNT, nch);
    write_reg(CFG_FEATURE_WINDOW, fw);
    write_reg(CFG_VOTE_WINDOW, vw);
    write_reg(CFG_VOTE_SPACING, vs);
    write_reg(CFG_MODEL_ENABLE, en);
  endtask

  function automatic req_t sample_item();
    req_t r;
    r = '0;
    r.req_type = REQ_SAMPLE;
    r.sample_0 = $urandom;
    r.sample_1 = $urandom;
    r.sample_2 = $urandom;
    r.sample_3 = $urandom;
    r.coef_class = $urandom;
    r.coef_index = $urandom;
    r.coef_value = $urandom;
    return r;
  endfunction

  // coefficient with a mostly useful spread: weights near Q2.13, small intercepts
  function automatic req_t coef_item(logic [2:0] cls, logic [2:0] idx);
    req_t r;
    r = sample_item();
    r.req_type = REQ_COEF;
    r.coef_class = cls;
    r.coef_index = idx;
    case ($urandom_range(0, 9))
      0:       r.coef_value = $urandom;
      1, 2:    r.coef_value = $urandom_range(0, 131071) - 65536;
      default: r.coef_value = idx == Channels ? $urandom_range(0, 8388607) - 4194304
                                              : $urandom_range(0, 32767) - 16384;
    endcase
    return r;
  endfunction

  task automatic load_all_coefs();
    for (int c = 0; c < MaxClasses; c++)
      for (int i = 0; i <= Channels; i++) send_item(coef_item(c, i));
  endtask

  // extremes, saturation, ignored addresses, unused request, disabled samples, ties
  task automatic test_directed();
    req_t r;
    load_all_coefs();
    drain();
    r = sample_item();
    send_item(r);                    // model disabled: no result
    r.req_type = 2'd3;
    send_item(r);                    // unused request kind
    set_config(8, 4, 1, 1, 1, 1);
    r = coef_item(0, 0); r.coef_value = 32'sh7fffffff; send_item(r);
    r = coef_item(0, 1); r.coef_value = 32'sh80000000; send_item(r);
    r = coef_item(1, 4); r.coef_value = 32'sh7fffffff; send_item(r);
    r = coef_item(2, 4); r.coef_value = 32'sh80000000; send_item(r);
    r = coef_item(3, 5); send_item(r);
    r = coef_item(3, 7); send_item(r);
    r = sample_item();
    r.sample_0 = 16'sh7fff; r.sample_1 = -16'sh8000;
    r.sample_2 = -16'sh8000; r.sample_3 = 16'sh7fff;
    send_item(r);
    r.sample_0 = -16'sh8000; r.sample_1 = 16'sh7fff;
    r.sample_2 = 16'sh0000; r.sample_3 = -16'sh0001;
    send_item(r);
    // all-zero coefficients: every score ties, label 0 wins
    for (int c = 0; c < MaxClasses; c++)
      for (int i = 0; i <= Channels; i++) begin
        r = coef_item(c, i);
        r.coef_value = 0;
        send_item(r);
      end
    send_item(sample_item());
    r.req_type = REQ_CLEAR;
    send_item(r);
    send_item(sample_item());
    drain();
    load_all_coefs();
    drain();
  endtask

  // sample-heavy random traffic with occasional loads, clears and noise
  task automatic random_phase(int n);
    req_t r;
    for (int j = 0; j < n; j++) begin
      case ($urandom_range(0, 39))
        0, 1:    r = coef_item($urandom, $urandom_range(0, 4));
        2:       r = coef_item($urandom, $urandom);
        3:       begin r = sample_item(); r.req_type = REQ_CLEAR; end
        4:       begin r = sample_item(); r.req_type = 2'd3; end
        default: r = sample_item();
      endcase
      send_item(r);
    end
    drain();
  endtask

  task automatic test_random_configs();
    int unsigned cc, fw, vw, vs;
    for (int p = 0; p < 10; p++) begin
      quiet_mode = (p % 5 == 4);
      cc = $urandom_range(0, 15);
      fw = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 4);
      vw = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 12);
      vs = $urandom_range(0, 5) == 0 ? $urandom_range(0, 127) : $urandom_range(0, 4);
      set_config(cc, $urandom_range(0, 7), fw, vw, vs, $urandom_range(0, 5) != 0);
      random_phase(fw > 8 ? 60 : 30);
    end
    quiet_mode = 1'b0;
  endtask

  // wide windows: counter wrap above 63, full downsampled vote, then shrunk windows
  task automatic test_window_extremes();
    set_config(8, 4, 64, 64, 1, 1);
    random_phase(140);
    set_config(8, 4, 3, 64, 7, 1);
    random_phase(60);
    set_config(2, 1, 2, 40, 0, 1);  // shrink: windows stay full, stale labels dropped
    random_phase(30);
    set_config(5, 2, 1, 9, 3, 1);
    random_phase(30);
  endtask

  // long receiver hold-off while the sender keeps offering, then a full pause
  task automatic test_backpressure();
    set_config(3, 2, 1, 4, 2, 1);
    hold_left = 400;
    quiet_mode = 1'b1;
    for (int j = 0; j < 30; j++) send_item(sample_item());
    quiet_mode = 1'b0;
    @(negedge clk);
    req_if.valid = 1'b0;
    wait (expected_results.size() == 0);
    for (int j = 0; j < 20; j++) send_item(sample_item());
    drain();
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    req_if.valid = 1'b0;
    req_if.data = '0;
    items_sent = 0;
    quiet_mode = 1'b0;
    reg_classes = 2; reg_channels = 4; reg_fwin = 1;
    reg_vwin = 1; reg_spacing = 1; reg_enable = 0;
    samples_in = 0; labels_in = 0; pace_count = 0;
    vote_class = '0; vote_valid = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_random_configs();
    test_window_extremes();
    test_backpressure();

    wait (expected_results.size() == 0);
    repeat (SettleCycles) @(posedge clk);
    $display("Covered %0d items, %0d frame results and %0d votes over", items_sent,
             frames_seen, votes_seen);
    $display("directed extremes, random settings, wide windows and a long stall.");
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
